// ===== rtl/core/spa_pkg.sv =====
// Shared types and constants for the slot pool allocator.
// Holds request and status codes, field widths and the slot memory word.
// No dependencies.
package spa_pkg;

	localparam int MAX_SLOTS = 1024;
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int CFG_AW    = 3;
	localparam int CFG_DW    = 32;

	localparam logic [2:0] REQ_ALLOC = 3'd0;
	localparam logic [2:0] REQ_FREE  = 3'd1;
	localparam logic [2:0] REQ_QUERY = 3'd2;
	localparam logic [2:0] REQ_CLEAR = 3'd3;
	localparam logic [2:0] REQ_WALK  = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Register select, taken from paddr[2].
	localparam logic CFG_REG_SLOT_LIMIT = 1'b0;

	// One entry of the slot memory: free-list link and in-use flag.
	typedef struct packed {
		logic [IDX_W-1:0] link;
		logic             used;
	} slot_word_t;

endpackage

// ===== rtl/core/slot_pool_allocator.sv =====
// Slot pool allocator: free-list allocator over slot indices with a walk over in-use slots.
// Query, clear, bump allocation, unknown requests and out-of-range frees finish in the idle
// state; free and free-list allocation read the slot memory, then write it back (a free only
// if the slot was in use); a walk reads positions in turn until it finds an in-use slot or
// reaches the bump pointer. New items are taken only in idle, not while a result is held.
// Reset clears control state and sets slot_limit to 1024; the slot memory is not cleared.
module slot_pool_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [spa_pkg::CFG_AW-1:0]  paddr,
	input  logic [spa_pkg::CFG_DW-1:0]  pwdata,
	output logic [spa_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  req_type,
	input  logic [spa_pkg::IDX_W-1:0]   slot_index,
	input  logic [spa_pkg::IDX_W-1:0]   skip_count,
	input  logic                        walk_restart,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        ok,
	output logic [spa_pkg::IDX_W-1:0]   slot_out,
	output logic [1:0]                  status,
	output logic [spa_pkg::CNT_W-1:0]   in_use_count
);
	import spa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_FREE_RD,
		S_WALK_CHK,
		S_HOLD
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  slot_limit_q;
	logic [IDX_W-1:0]  free_head_q, free_head_d;
	logic              nonempty_q, nonempty_d;
	logic [CNT_W-1:0]  bump_q, bump_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  cursor_q, cursor_d;
	logic [IDX_W-1:0]  addr_s1, addr_d;
	logic [IDX_W-1:0]  skip_q;

	// Slot memory: link and in-use flag per slot, one write and one read per cycle.
	slot_word_t        slot_mem [MAX_SLOTS];
	slot_word_t        mem_rdata_s1;
	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	slot_word_t        mem_wdata;

	logic              fin, fin_ok;
	logic [IDX_W-1:0]  fin_slot;
	logic [1:0]        fin_status;
	logic              out_free;

	logic              hold_ok_q;
	logic [IDX_W-1:0]  hold_slot_q;
	logic [1:0]        hold_status_q;
	logic [CNT_W-1:0]  hold_count_q;

	logic [CNT_W-1:0]  limit_c;
	logic [CNT_W-1:0]  start_c;
	logic [CNT_W-1:0]  walk_base_c;
	logic [IDX_W-1:0]  skip_c;
	logic [CNT_W:0]    walk_sum_c;
	logic [CNT_W-1:0]  walk_next_c;
	logic              idx_in_range_c;

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == CFG_REG_SLOT_LIMIT) ?
	                  {{(CFG_DW-CNT_W){1'b0}}, slot_limit_q} : '0;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	assign limit_c        = (slot_limit_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_limit_q;
	assign start_c        = walk_restart ? '0 : cursor_q;
	assign walk_base_c    = (state_q == S_IDLE) ? start_c : cursor_q;
	// The stride of a walk in progress comes from the item that started it.
	assign skip_c         = (state_q == S_IDLE) ? skip_count : skip_q;
	assign walk_sum_c     = {1'b0, walk_base_c} + {{(CNT_W-IDX_W+1){1'b0}}, skip_c}
	                        + (CNT_W+1)'(1);
	assign walk_next_c    = (walk_sum_c > (CNT_W+1)'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
	                        : walk_sum_c[CNT_W-1:0];
	assign idx_in_range_c = ({1'b0, slot_index} < bump_q);

	// Every slot below the bump pointer has been written since the last clear, and all
	// reads are limited to that range, so the bump pointer doubles as the fill count.
	always_comb begin
		state_d     = state_q;
		free_head_d = free_head_q;
		nonempty_d  = nonempty_q;
		bump_d      = bump_q;
		count_d     = count_q;
		cursor_d    = cursor_q;
		addr_d      = addr_s1;
		fin         = 1'b0;
		fin_ok      = 1'b0;
		fin_slot    = '0;
		fin_status  = ST_BAD;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = addr_s1;
		mem_raddr   = '0;
		mem_wdata   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (req_type)
						REQ_ALLOC: begin
							if (nonempty_q) begin
								mem_re    = 1'b1;
								mem_raddr = free_head_q;
								addr_d    = free_head_q;
								state_d   = S_ALLOC_RD;
							end else if (bump_q < limit_c) begin
								mem_we         = 1'b1;
								mem_waddr      = bump_q[IDX_W-1:0];
								mem_wdata.used = 1'b1;
								bump_d         = bump_q + CNT_W'(1);
								count_d        = count_q + CNT_W'(1);
								fin            = 1'b1;
								fin_ok         = 1'b1;
								fin_slot       = bump_q[IDX_W-1:0];
								fin_status     = ST_OK;
							end else begin
								fin        = 1'b1;
								fin_status = ST_FULL;
							end
						end
						REQ_FREE: begin
							if (idx_in_range_c) begin
								mem_re    = 1'b1;
								mem_raddr = slot_index;
								addr_d    = slot_index;
								state_d   = S_FREE_RD;
							end else begin
								fin = 1'b1;
							end
						end
						REQ_QUERY: begin
							fin = 1'b1;
							if (idx_in_range_c) begin
								fin_ok     = 1'b1;
								fin_status = ST_OK;
							end
						end
						REQ_CLEAR: begin
							free_head_d = '0;
							nonempty_d  = 1'b0;
							bump_d      = '0;
							count_d     = '0;
							cursor_d    = '0;
							fin         = 1'b1;
							fin_ok      = 1'b1;
							fin_status  = ST_OK;
						end
						REQ_WALK: begin
							if (start_c < bump_q) begin
								mem_re    = 1'b1;
								mem_raddr = start_c[IDX_W-1:0];
								addr_d    = start_c[IDX_W-1:0];
								cursor_d  = walk_next_c;
								state_d   = S_WALK_CHK;
							end else begin
								cursor_d   = start_c;
								fin        = 1'b1;
								fin_status = ST_DONE;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC_RD: begin
				mem_we         = 1'b1;
				mem_wdata.link = mem_rdata_s1.link;
				mem_wdata.used = 1'b1;
				free_head_d    = mem_rdata_s1.link;
				count_d        = count_q + CNT_W'(1);
				nonempty_d     = (bump_q > count_q + CNT_W'(1));
				fin            = 1'b1;
				fin_ok         = 1'b1;
				fin_slot       = addr_s1;
				fin_status     = ST_OK;
			end
			S_FREE_RD: begin
				fin = 1'b1;
				if (mem_rdata_s1.used) begin
					mem_we         = 1'b1;
					mem_wdata.link = free_head_q;
					mem_wdata.used = 1'b0;
					free_head_d    = addr_s1;
					nonempty_d     = 1'b1;
					count_d        = count_q - CNT_W'(1);
					fin_ok         = 1'b1;
					fin_status     = ST_OK;
				end
			end
			S_WALK_CHK: begin
				if (mem_rdata_s1.used) begin
					fin        = 1'b1;
					fin_ok     = 1'b1;
					fin_slot   = addr_s1;
					fin_status = ST_OK;
				end else if (cursor_q < bump_q) begin
					mem_re    = 1'b1;
					mem_raddr = cursor_q[IDX_W-1:0];
					addr_d    = cursor_q[IDX_W-1:0];
					cursor_d  = walk_next_c;
				end else begin
					fin        = 1'b1;
					fin_status = ST_DONE;
				end
			end
			S_HOLD: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_s1 <= slot_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_limit_q <= CNT_W'(1024);
			free_head_q  <= '0;
			nonempty_q   <= 1'b0;
			bump_q       <= '0;
			count_q      <= '0;
			cursor_q     <= '0;
			out_valid    <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_head_q <= free_head_d;
			nonempty_q  <= nonempty_d;
			bump_q      <= bump_d;
			count_q     <= count_d;
			cursor_q    <= cursor_d;
			if (psel && penable && pwrite && (paddr[2] == CFG_REG_SLOT_LIMIT)) begin
				slot_limit_q <= pwdata[CNT_W-1:0];
			end
			if ((fin || state_q == S_HOLD) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result and hold registers carry payload only.
	always_ff @(posedge clk) begin
		addr_s1 <= addr_d;
		if (in_valid && in_ready) begin
			skip_q <= skip_count;
		end
		if (fin && out_free) begin
			ok           <= fin_ok;
			slot_out     <= fin_slot;
			status       <= fin_status;
			in_use_count <= count_d;
		end else if (state_q == S_HOLD && out_free) begin
			ok           <= hold_ok_q;
			slot_out     <= hold_slot_q;
			status       <= hold_status_q;
			in_use_count <= hold_count_q;
		end
		if (fin && !out_free) begin
			hold_ok_q     <= fin_ok;
			hold_slot_q   <= fin_slot;
			hold_status_q <= fin_status;
			hold_count_q  <= count_d;
		end
	end

	a_count_below_bump: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bump_q)
		else $error("allocated count exceeds bump pointer");

	a_list_matches_counts: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q == (bump_q != count_q))
		else $error("free list flag disagrees with released slot count");

	a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("slot memory read and write issued in the same cycle");

	a_hold_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HOLD) |-> out_valid)
		else $error("result held while output register is empty");

	a_cursor_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cursor_q <= CNT_W'(MAX_SLOTS)) && (bump_q <= CNT_W'(MAX_SLOTS)))
		else $error("walk cursor or bump pointer beyond pool size");

endmodule
